FILE: rtl/tlf_pkg.sv
// ============================================================================
// tlf_pkg: shared types and constants of the track line fitter
// Payload structs, register codes, pipeline stage map and datapath widths.
// ============================================================================
`default_nettype none

package tlf_pkg;

  localparam int NUM_PLANES = 5;
  localparam int POS_W      = 16;
  localparam int WIN_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int Q_FRAC     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INNER_WINDOW = 2'd0,
    CFG_LAST_WINDOW  = 2'd1,
    CFG_TARGET_BOUND = 2'd2
  } cfg_reg_t;

  localparam logic [WIN_W-1:0] INNER_WINDOW_RST = 15'd2400;
  localparam logic [WIN_W-1:0] LAST_WINDOW_RST  = 15'd1600;
  localparam logic [WIN_W-1:0] TARGET_BOUND_RST = 15'd480;

  // hit lane products
  localparam int ZZ_W = 31;
  localparam int ZP_W = 32;
  // sums and normal-equation terms
  localparam int N_W    = 4;
  localparam int SUMZ_W = 19;
  localparam int SZZ_W  = 34;
  localparam int SZP_W  = 34;
  localparam int PS_W   = 38;
  localparam int PL_W   = 52;
  localparam int DEN_W  = 36;
  // divider
  localparam int Q_W    = 32;
  localparam int DIV_NW = 56;
  localparam int DIV_RW = DEN_W + 1;
  localparam int DIVX_W = DEN_W + Q_W;
  // residual lane
  localparam int PROD_W = 48;
  localparam int PI_W   = 33;
  localparam int NUM_W  = 50;
  localparam int MAG_W  = 51;
  localparam int RQ_W   = MAG_W - Q_FRAC;
  localparam int SQ_W   = 64;
  localparam int CHI_W  = 48;
  localparam int CHS_W  = CHI_W + 3;

  localparam logic signed [Q_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam longint unsigned HALF_RANGE = 64'h8000_0000;
  localparam longint unsigned ONE_Q16    = 64'h1_0000;
  localparam longint unsigned ROUND_HALF = 64'h8000;
  localparam logic [CHI_W-1:0] CHI_MAX   = 48'hffff_ffff_ffff;

  // pipeline stage map
  localparam int ST_MERGE     = 1;
  localparam int MERGE_STAGES = 4;
  localparam int ST_DIV       = ST_MERGE + MERGE_STAGES;
  localparam int DIV_STAGES   = Q_W + 2;
  localparam int ST_RES       = ST_DIV + DIV_STAGES;
  localparam int RES_STAGES   = 5;
  localparam int ST_ACC       = ST_RES + 2;
  localparam int ST_OUT       = ST_RES + RES_STAGES;
  localparam int NSTG         = ST_OUT + 1;

  // masks that are never fitted: any mask up to 5'd4, plane 3 alone, planes 2/3, or plane 4 alone
  localparam logic [NUM_PLANES-1:0] MASK_LOW_LIMIT = 5'd4;
  localparam logic [NUM_PLANES-1:0] MASK_P3        = 5'd8;
  localparam logic [NUM_PLANES-1:0] MASK_P23       = 5'd12;
  localparam logic [NUM_PLANES-1:0] MASK_P4        = 5'd16;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_0;
    logic signed [POS_W-1:0] pos_1;
    logic signed [POS_W-1:0] pos_2;
    logic signed [POS_W-1:0] pos_3;
    logic signed [POS_W-1:0] pos_4;
    logic signed [POS_W-1:0] z_0;
    logic signed [POS_W-1:0] z_1;
    logic signed [POS_W-1:0] z_2;
    logic signed [POS_W-1:0] z_3;
    logic signed [POS_W-1:0] z_4;
    logic [NUM_PLANES-1:0]   timing_ok;
  } in_t;

  typedef struct packed {
    logic                    accepted;
    logic [NUM_PLANES-1:0]   hit_mask;
    logic signed [Q_W-1:0]   slope;
    logic signed [Q_W-1:0]   intercept;
    logic [CHI_W-1:0]        chi_square;
    logic [1:0]              degrees_free;
    logic signed [Q_W-1:0]   residual_0;
    logic signed [Q_W-1:0]   residual_1;
    logic signed [Q_W-1:0]   residual_2;
    logic signed [Q_W-1:0]   residual_3;
    logic signed [Q_W-1:0]   residual_4;
  } out_t;

  // event data that rides along the pipeline
  typedef struct packed {
    logic [NUM_PLANES-1:0]            mask;
    logic [NUM_PLANES-1:0][POS_W-1:0] pos;
    logic [NUM_PLANES-1:0][POS_W-1:0] z;
    logic                             fit;
    logic [1:0]                       dof;
    logic [Q_W-1:0]                   slope;
    logic [Q_W-1:0]                   icpt;
    logic                             acc;
  } meta_t;

  function automatic logic mask_fittable(input logic [NUM_PLANES-1:0] m);
    return !(m <= MASK_LOW_LIMIT || m == MASK_P3 || m == MASK_P23 || m == MASK_P4);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tlf_hit_lane.sv
// ============================================================================
// tlf_hit_lane: per-plane window test and moment products
// One register stage: hit flag, z*z and z*pos for one plane.
// ============================================================================
`default_nettype none

module tlf_hit_lane (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [tlf_pkg::POS_W-1:0] pos,
  input  logic signed [tlf_pkg::POS_W-1:0] z,
  input  logic                           timing,
  input  logic [tlf_pkg::WIN_W-1:0]      win,
  output logic                           hit,
  output logic [tlf_pkg::ZZ_W-1:0]       zz,
  output logic signed [tlf_pkg::ZP_W-1:0] zp
);

  logic signed [tlf_pkg::POS_W:0]   pos_x;
  logic [tlf_pkg::POS_W:0]          apos;
  logic signed [tlf_pkg::ZP_W-1:0]  zsq;

  assign pos_x = (tlf_pkg::POS_W+1)'(pos);
  assign apos  = pos_x[tlf_pkg::POS_W] ? (tlf_pkg::POS_W+1)'(-pos_x)
                                       : (tlf_pkg::POS_W+1)'(pos_x);
  assign zsq   = tlf_pkg::ZP_W'(z) * tlf_pkg::ZP_W'(z);

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= timing && (apos < (tlf_pkg::POS_W+1)'(win));
      zz  <= zsq[tlf_pkg::ZZ_W-1:0];
      zp  <= tlf_pkg::ZP_W'(z) * tlf_pkg::ZP_W'(pos);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tlf_merge.sv
// ============================================================================
// tlf_merge: combines lane results into the normal equations
// Masked sums, cross products, determinant and rounded divider operands.
// ============================================================================
`default_nettype none

module tlf_merge (
  input  logic clk,
  input  logic [tlf_pkg::MERGE_STAGES-1:0] en,
  input  logic [tlf_pkg::NUM_PLANES-1:0]   hit,
  input  logic [tlf_pkg::ZZ_W-1:0]         zz  [tlf_pkg::NUM_PLANES],
  input  logic signed [tlf_pkg::ZP_W-1:0]  zp  [tlf_pkg::NUM_PLANES],
  input  logic signed [tlf_pkg::POS_W-1:0] pos [tlf_pkg::NUM_PLANES],
  input  logic signed [tlf_pkg::POS_W-1:0] z   [tlf_pkg::NUM_PLANES],
  output logic                             fit,
  output logic [1:0]                       dof,
  output logic [tlf_pkg::DIV_NW-1:0]       num_s,
  output logic [tlf_pkg::DIV_NW-1:0]       num_i,
  output logic [tlf_pkg::DEN_W-1:0]        den,
  output logic                             neg_s,
  output logic                             neg_i
);

  logic signed [tlf_pkg::N_W-1:0]    n_c;
  logic signed [tlf_pkg::SUMZ_W-1:0] sz_c, sp_c;
  logic signed [tlf_pkg::SZZ_W-1:0]  szz_c;
  logic signed [tlf_pkg::SZP_W-1:0]  szp_c;

  // stage 1
  logic                              fok1;
  logic signed [tlf_pkg::N_W-1:0]    n1;
  logic signed [tlf_pkg::SUMZ_W-1:0] sz1, sp1;
  logic signed [tlf_pkg::SZZ_W-1:0]  szz1;
  logic signed [tlf_pkg::SZP_W-1:0]  szp1;
  // stage 2
  logic                              fok2;
  logic signed [tlf_pkg::N_W-1:0]    n2;
  logic signed [tlf_pkg::PS_W-1:0]   nszz2, szsq2, nszp2, szsp2;
  logic signed [tlf_pkg::PL_W-1:0]   szzsp2, szszp2;
  // stage 3
  logic                              fok3;
  logic signed [tlf_pkg::N_W-1:0]    n3;
  logic signed [tlf_pkg::PS_W-1:0]   den3, ns3;
  logic signed [tlf_pkg::PL_W-1:0]   ni3;

  logic [tlf_pkg::PS_W-1:0] ans;
  logic [tlf_pkg::PL_W-1:0] ani;

  always_comb begin
    n_c   = '0;
    sz_c  = '0;
    sp_c  = '0;
    szz_c = '0;
    szp_c = '0;
    for (int i = 0; i < tlf_pkg::NUM_PLANES; i++) begin
      if (hit[i]) begin
        n_c   = n_c + tlf_pkg::N_W'(1);
        sz_c  = sz_c + tlf_pkg::SUMZ_W'(z[i]);
        sp_c  = sp_c + tlf_pkg::SUMZ_W'(pos[i]);
        szz_c = szz_c + tlf_pkg::SZZ_W'(zz[i]);
        szp_c = szp_c + tlf_pkg::SZP_W'(zp[i]);
      end
    end
  end

  assign ans = ns3[tlf_pkg::PS_W-1] ? tlf_pkg::PS_W'(-ns3) : tlf_pkg::PS_W'(ns3);
  assign ani = ni3[tlf_pkg::PL_W-1] ? tlf_pkg::PL_W'(-ni3) : tlf_pkg::PL_W'(ni3);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fok1 <= tlf_pkg::mask_fittable(hit);
      n1   <= n_c;
      sz1  <= sz_c;
      sp1  <= sp_c;
      szz1 <= szz_c;
      szp1 <= szp_c;
    end
    if (en[1]) begin
      fok2   <= fok1;
      n2     <= n1;
      nszz2  <= tlf_pkg::PS_W'(n1) * tlf_pkg::PS_W'(szz1);
      szsq2  <= tlf_pkg::PS_W'(sz1) * tlf_pkg::PS_W'(sz1);
      nszp2  <= tlf_pkg::PS_W'(n1) * tlf_pkg::PS_W'(szp1);
      szsp2  <= tlf_pkg::PS_W'(sz1) * tlf_pkg::PS_W'(sp1);
      szzsp2 <= tlf_pkg::PL_W'(szz1) * tlf_pkg::PL_W'(sp1);
      szszp2 <= tlf_pkg::PL_W'(sz1) * tlf_pkg::PL_W'(szp1);
    end
    if (en[2]) begin
      fok3 <= fok2;
      n3   <= n2;
      den3 <= nszz2 - szsq2;
      ns3  <= nszp2 - szsp2;
      ni3  <= szzsp2 - szszp2;
    end
    if (en[3]) begin
      // halves round away from zero: add den/2 to the magnitude
      fit   <= fok3 && (den3 > 0);
      dof   <= 2'(n3 - tlf_pkg::N_W'(2));
      den   <= den3[tlf_pkg::DEN_W-1:0];
      neg_s <= ns3[tlf_pkg::PS_W-1];
      neg_i <= ni3[tlf_pkg::PL_W-1];
      num_s <= (tlf_pkg::DIV_NW'(ans) << tlf_pkg::Q_FRAC)
             + tlf_pkg::DIV_NW'(den3[tlf_pkg::DEN_W-1:0] >> 1);
      num_i <= tlf_pkg::DIV_NW'(ani)
             + tlf_pkg::DIV_NW'(den3[tlf_pkg::DEN_W-1:0] >> 1);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tlf_div.sv
// ============================================================================
// tlf_div: pipelined restoring divider with signed saturation
// Overflow check, one quotient bit per stage, then sign and clamp to 32 bits.
// ============================================================================
`default_nettype none

module tlf_div (
  input  logic                           clk,
  input  logic [tlf_pkg::DIV_STAGES-1:0] en,
  input  logic [tlf_pkg::DIV_NW-1:0]     num,
  input  logic [tlf_pkg::DEN_W-1:0]      den,
  input  logic                           neg,
  output logic signed [tlf_pkg::Q_W-1:0] quot
);

  localparam int NB = tlf_pkg::Q_W;

  logic [tlf_pkg::DIV_RW-1:0] r   [NB+1];
  logic [NB-1:0]              lo  [NB+1];
  logic [NB-1:0]              q   [NB+1];
  logic [tlf_pkg::DEN_W-1:0]  d   [NB+1];
  logic                       sg  [NB+1];
  logic                       ovf [NB+1];
  logic [tlf_pkg::DIV_RW-1:0] t   [NB+1];

  always_comb begin
    t[0] = '0;
    for (int j = 1; j <= NB; j++) begin
      t[j] = {r[j-1][tlf_pkg::DIV_RW-2:0], lo[j-1][NB-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ovf[0] <= tlf_pkg::DIVX_W'(num) >= {den, {NB{1'b0}}};
      r[0]   <= tlf_pkg::DIV_RW'(num >> NB);
      lo[0]  <= num[NB-1:0];
      q[0]   <= '0;
      d[0]   <= den;
      sg[0]  <= neg;
    end
    for (int j = 1; j <= NB; j++) begin
      if (en[j]) begin
        if (t[j] >= tlf_pkg::DIV_RW'(d[j-1])) begin
          r[j] <= t[j] - tlf_pkg::DIV_RW'(d[j-1]);
          q[j] <= {q[j-1][NB-2:0], 1'b1};
        end else begin
          r[j] <= t[j];
          q[j] <= {q[j-1][NB-2:0], 1'b0};
        end
        lo[j]  <= lo[j-1] << 1;
        d[j]   <= d[j-1];
        sg[j]  <= sg[j-1];
        ovf[j] <= ovf[j-1];
      end
    end
    if (en[NB+1]) begin
      if (ovf[NB]) begin
        quot <= sg[NB] ? tlf_pkg::S32_MIN : tlf_pkg::S32_MAX;
      end else if (!sg[NB]) begin
        quot <= q[NB][NB-1] ? tlf_pkg::S32_MAX : $signed(q[NB]);
      end else begin
        quot <= (q[NB] > NB'(tlf_pkg::HALF_RANGE)) ? tlf_pkg::S32_MIN
                                                   : $signed(-q[NB]);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tlf_res_lane.sv
// ============================================================================
// tlf_res_lane: per-plane residual and its square
// Five stages: slope*z, numerator, rounding, clamp, square.
// ============================================================================
`default_nettype none

module tlf_res_lane (
  input  logic                           clk,
  input  logic [tlf_pkg::RES_STAGES-1:0] en,
  input  logic signed [tlf_pkg::Q_W-1:0]   slope,
  input  logic signed [tlf_pkg::Q_W-1:0]   icpt,
  input  logic signed [tlf_pkg::POS_W-1:0] pos,
  input  logic signed [tlf_pkg::POS_W-1:0] z,
  output logic signed [tlf_pkg::Q_W-1:0]   res,
  output logic [tlf_pkg::SQ_W-1:0]         sq
);

  logic signed [tlf_pkg::PROD_W-1:0] prod1;
  logic signed [tlf_pkg::PI_W-1:0]   pi1;
  logic signed [tlf_pkg::NUM_W-1:0]  num2;
  logic                              neg3;
  logic [tlf_pkg::MAG_W-1:0]         mag3;
  logic signed [tlf_pkg::Q_W-1:0]    res4;
  logic [tlf_pkg::Q_W-1:0]           ares4;

  logic [tlf_pkg::NUM_W-1:0] anum;
  logic [tlf_pkg::RQ_W-1:0]  qv;
  logic                      big;

  assign anum = num2[tlf_pkg::NUM_W-1] ? tlf_pkg::NUM_W'(-num2) : tlf_pkg::NUM_W'(num2);
  assign qv   = mag3[tlf_pkg::MAG_W-1:tlf_pkg::Q_FRAC];
  assign big  = qv >= tlf_pkg::RQ_W'(tlf_pkg::HALF_RANGE);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod1 <= tlf_pkg::PROD_W'(slope) * tlf_pkg::PROD_W'(z);
      pi1   <= tlf_pkg::PI_W'(pos) - tlf_pkg::PI_W'(icpt);
    end
    if (en[1]) begin
      num2 <= (tlf_pkg::NUM_W'(pi1) <<< tlf_pkg::Q_FRAC) - tlf_pkg::NUM_W'(prod1);
    end
    if (en[2]) begin
      neg3 <= num2[tlf_pkg::NUM_W-1];
      mag3 <= tlf_pkg::MAG_W'(anum) + tlf_pkg::MAG_W'(tlf_pkg::ROUND_HALF);
    end
    if (en[3]) begin
      if (neg3) begin
        res4  <= big ? tlf_pkg::S32_MIN : $signed(-tlf_pkg::Q_W'(qv));
        ares4 <= big ? tlf_pkg::Q_W'(tlf_pkg::HALF_RANGE) : tlf_pkg::Q_W'(qv);
      end else begin
        res4  <= big ? tlf_pkg::S32_MAX : $signed(tlf_pkg::Q_W'(qv));
        ares4 <= big ? tlf_pkg::Q_W'(tlf_pkg::S32_MAX) : tlf_pkg::Q_W'(qv);
      end
    end
    if (en[4]) begin
      res <= res4;
      sq  <= tlf_pkg::SQ_W'(ares4) * tlf_pkg::SQ_W'(ares4);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/track_line_fit_with_hit_mask_core.sv
// ============================================================================
// track_line_fit_with_hit_mask_core: five-plane straight-line track fitter
// Hit mask, least-squares line, target-bound test, residuals and chi-square.
// ============================================================================
//
//  channel  signals                          transaction when
//  -------  -------------------------------  ---------------------------
//  in       in_valid  in_stall  in_item      in_valid  && !in_stall
//  out      out_valid out_stall out_item     out_valid && !out_stall
//  cfg      cfg_valid cfg_ready cfg_index    cfg_valid && cfg_ready
//           cfg_data
//
//  One event per cycle sustained while out_stall is low. Most of the pipeline
//  length lies in the two 32-stage quotient pipelines (one quotient bit per
//  stage) for slope and intercept. Reset clears the stage valid bits and loads
//  register defaults. A stalled output freezes only the stages behind it that
//  are full: a stage moves when any stage at or ahead of it holds a bubble, so
//  input keeps flowing into an emptied pipeline while a result waits.
//
`default_nettype none

module track_line_fit_with_hit_mask_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tlf_pkg::in_t                      in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tlf_pkg::out_t                     out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlf_pkg::WIN_W-1:0]         cfg_data
);

  localparam int NP = tlf_pkg::NUM_PLANES;
  localparam int NS = tlf_pkg::NSTG;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [tlf_pkg::WIN_W-1:0] inner_window, last_window, target_bound;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_window <= tlf_pkg::INNER_WINDOW_RST;
      last_window  <= tlf_pkg::LAST_WINDOW_RST;
      target_bound <= tlf_pkg::TARGET_BOUND_RST;
    end else if (cfg_valid) begin
      case (tlf_pkg::cfg_reg_t'(cfg_index))
        tlf_pkg::CFG_INNER_WINDOW: inner_window <= cfg_data;
        tlf_pkg::CFG_LAST_WINDOW:  last_window  <= cfg_data;
        tlf_pkg::CFG_TARGET_BOUND: target_bound <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage valids and enables
  // ---------------------------------------------------------------------
  logic [NS-1:0] v, en;

  // a stage may load when the output is free or a bubble sits at or ahead
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = !out_stall || !(&(v | (((NS)'(1) << k) - (NS)'(1))));
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // event data carried along the stages
  // ---------------------------------------------------------------------
  tlf_pkg::meta_t meta [tlf_pkg::ST_OUT];
  tlf_pkg::meta_t src  [tlf_pkg::ST_OUT];
  tlf_pkg::meta_t m0;

  logic signed [tlf_pkg::POS_W-1:0] in_pos [NP];
  logic signed [tlf_pkg::POS_W-1:0] in_z   [NP];

  assign in_pos[0] = in_item.pos_0;
  assign in_pos[1] = in_item.pos_1;
  assign in_pos[2] = in_item.pos_2;
  assign in_pos[3] = in_item.pos_3;
  assign in_pos[4] = in_item.pos_4;
  assign in_z[0]   = in_item.z_0;
  assign in_z[1]   = in_item.z_1;
  assign in_z[2]   = in_item.z_2;
  assign in_z[3]   = in_item.z_3;
  assign in_z[4]   = in_item.z_4;

  // lane outputs
  logic [NP-1:0]                    hit;
  logic [tlf_pkg::ZZ_W-1:0]         zz  [NP];
  logic signed [tlf_pkg::ZP_W-1:0]  zp  [NP];
  logic signed [tlf_pkg::POS_W-1:0] m_pos0 [NP];
  logic signed [tlf_pkg::POS_W-1:0] m_z0   [NP];
  logic signed [tlf_pkg::POS_W-1:0] m_posr [NP];
  logic signed [tlf_pkg::POS_W-1:0] m_zr   [NP];
  logic signed [tlf_pkg::Q_W-1:0]   res [NP];
  logic [tlf_pkg::SQ_W-1:0]         sq  [NP];

  // merge and divider outputs
  logic                             mg_fit;
  logic [1:0]                       mg_dof;
  logic [tlf_pkg::DIV_NW-1:0]       mg_num_s, mg_num_i;
  logic [tlf_pkg::DEN_W-1:0]        mg_den;
  logic                             mg_neg_s, mg_neg_i;
  logic signed [tlf_pkg::Q_W-1:0]   slope_q, icpt_q;

  // acceptance test registers
  logic [tlf_pkg::Q_W-1:0]          s1abs, iabs;
  logic [tlf_pkg::CHI_W-1:0]        lhs;
  logic [tlf_pkg::CHI_W-2:0]        rhs;
  logic signed [tlf_pkg::Q_W:0]     s1;

  always_comb begin
    m0      = '0;
    m0.mask = '0;
    for (int i = 0; i < NP; i++) begin
      m0.pos[i] = in_pos[i];
      m0.z[i]   = in_z[i];
    end
  end

  // each stage takes the one behind it, with fields filled in where found
  always_comb begin
    for (int k = 0; k < tlf_pkg::ST_OUT; k++) begin
      src[k] = (k == 0) ? m0 : meta[(k == 0) ? 0 : k - 1];
      if (k == tlf_pkg::ST_MERGE) src[k].mask = hit;
      if (k == tlf_pkg::ST_DIV) begin
        src[k].fit = mg_fit;
        src[k].dof = mg_dof;
      end
      if (k == tlf_pkg::ST_RES) begin
        src[k].slope = slope_q;
        src[k].icpt  = icpt_q;
      end
      if (k == tlf_pkg::ST_ACC) src[k].acc = lhs < tlf_pkg::CHI_W'(rhs);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < tlf_pkg::ST_OUT; k++) begin
      if (en[k]) meta[k] <= src[k];
    end
  end

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      m_pos0[i] = $signed(meta[0].pos[i]);
      m_z0[i]   = $signed(meta[0].z[i]);
      m_posr[i] = $signed(meta[tlf_pkg::ST_RES-1].pos[i]);
      m_zr[i]   = $signed(meta[tlf_pkg::ST_RES-1].z[i]);
    end
  end

  // ---------------------------------------------------------------------
  // hit lanes: window test and moment products, one per plane
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < NP; g++) begin : g_hit
    tlf_hit_lane u_hit (
      .clk    (clk),
      .en     (en[0]),
      .pos    (in_pos[g]),
      .z      (in_z[g]),
      .timing (in_item.timing_ok[g]),
      .win    ((g == NP - 1) ? last_window : inner_window),
      .hit    (hit[g]),
      .zz     (zz[g]),
      .zp     (zp[g])
    );
  end

  // ---------------------------------------------------------------------
  // merge: sums over hit planes, determinant and divider operands
  // ---------------------------------------------------------------------
  tlf_merge u_merge (
    .clk   (clk),
    .en    (en[tlf_pkg::ST_MERGE +: tlf_pkg::MERGE_STAGES]),
    .hit   (hit),
    .zz    (zz),
    .zp    (zp),
    .pos   (m_pos0),
    .z     (m_z0),
    .fit   (mg_fit),
    .dof   (mg_dof),
    .num_s (mg_num_s),
    .num_i (mg_num_i),
    .den   (mg_den),
    .neg_s (mg_neg_s),
    .neg_i (mg_neg_i)
  );

  // ---------------------------------------------------------------------
  // quotients for slope (Q16.16) and intercept
  // ---------------------------------------------------------------------
  tlf_div u_div_slope (
    .clk  (clk),
    .en   (en[tlf_pkg::ST_DIV +: tlf_pkg::DIV_STAGES]),
    .num  (mg_num_s),
    .den  (mg_den),
    .neg  (mg_neg_s),
    .quot (slope_q)
  );

  tlf_div u_div_icpt (
    .clk  (clk),
    .en   (en[tlf_pkg::ST_DIV +: tlf_pkg::DIV_STAGES]),
    .num  (mg_num_i),
    .den  (mg_den),
    .neg  (mg_neg_i),
    .quot (icpt_q)
  );

  // ---------------------------------------------------------------------
  // target bound: |icpt|*2^16 < bound*|2^16 + slope|
  // ---------------------------------------------------------------------
  assign s1 = (tlf_pkg::Q_W+1)'(slope_q) + (tlf_pkg::Q_W+1)'(tlf_pkg::ONE_Q16);

  always_ff @(posedge clk) begin
    if (en[tlf_pkg::ST_RES]) begin
      s1abs <= s1[tlf_pkg::Q_W] ? tlf_pkg::Q_W'(-s1) : tlf_pkg::Q_W'(s1);
      iabs  <= icpt_q[tlf_pkg::Q_W-1] ? tlf_pkg::Q_W'(-icpt_q) : tlf_pkg::Q_W'(icpt_q);
    end
    if (en[tlf_pkg::ST_RES+1]) begin
      lhs <= {iabs, {tlf_pkg::Q_FRAC{1'b0}}};
      rhs <= (tlf_pkg::CHI_W-1)'(target_bound) * (tlf_pkg::CHI_W-1)'(s1abs);
    end
  end

  // ---------------------------------------------------------------------
  // residual lanes, one per plane
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < NP; g++) begin : g_res
    tlf_res_lane u_res (
      .clk   (clk),
      .en    (en[tlf_pkg::ST_RES +: tlf_pkg::RES_STAGES]),
      .slope (slope_q),
      .icpt  (icpt_q),
      .pos   (m_posr[g]),
      .z     (m_zr[g]),
      .res   (res[g]),
      .sq    (sq[g])
    );
  end

  // ---------------------------------------------------------------------
  // output register: chi-square and result assembly
  // ---------------------------------------------------------------------
  tlf_pkg::meta_t            ml;
  logic                      acc_all;
  logic                      chi_big;
  logic [tlf_pkg::CHS_W-1:0] chi_sum;
  logic [tlf_pkg::CHI_W-1:0] chi;

  assign ml      = meta[tlf_pkg::ST_OUT-1];
  assign acc_all = ml.fit && ml.acc;

  always_comb begin
    chi_big = 1'b0;
    chi_sum = '0;
    for (int i = 0; i < NP; i++) begin
      if (ml.mask[i]) begin
        if (|sq[i][tlf_pkg::SQ_W-1:tlf_pkg::CHI_W]) chi_big = 1'b1;
        chi_sum = chi_sum + tlf_pkg::CHS_W'(sq[i][tlf_pkg::CHI_W-1:0]);
      end
    end
    chi = (chi_big || chi_sum > tlf_pkg::CHS_W'(tlf_pkg::CHI_MAX))
        ? tlf_pkg::CHI_MAX : chi_sum[tlf_pkg::CHI_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[tlf_pkg::ST_OUT]) begin
      out_item.accepted     <= acc_all;
      out_item.hit_mask     <= ml.mask;
      out_item.slope        <= acc_all ? $signed(ml.slope) : '0;
      out_item.intercept    <= acc_all ? $signed(ml.icpt) : '0;
      out_item.chi_square   <= acc_all ? chi : '0;
      out_item.degrees_free <= acc_all ? ml.dof : '0;
      out_item.residual_0   <= acc_all ? res[0] : '0;
      out_item.residual_1   <= acc_all ? res[1] : '0;
      out_item.residual_2   <= acc_all ? res[2] : '0;
      out_item.residual_3   <= acc_all ? res[3] : '0;
      out_item.residual_4   <= acc_all ? res[4] : '0;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.accepted |->
      out_item.slope == 0 && out_item.intercept == 0 && out_item.chi_square == 0)
    else $error("rejected result carries nonzero fit fields");

  a_accept_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.accepted |->
      tlf_pkg::mask_fittable(out_item.hit_mask) &&
      out_item.degrees_free == 2'($countones(out_item.hit_mask) - 2))
    else $error("accepted fit with unfittable mask or wrong degrees of freedom");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Track line fitter testbench
// Drives detector events into the five-plane line fitter and checks every
// result against an in-bench fixed-point predictor or a row's own expectation.
// Covers register extremes, random valid/stall bursts, one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it; a write there must be ignored
  localparam logic [tlf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int FLUSH_CYCLES = 60;     // longer than the pipeline is deep
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;    // long enough to fill the pipeline
  localparam int PHASE_EVENTS = 310;
  localparam int NUM_PHASES   = 5;
  localparam int QUIET_EVENTS = 150;    // tail of the run with no idling
  localparam longint Q1 = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tlf_pkg::in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tlf_pkg::out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tlf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tlf_pkg::WIN_W-1:0] cfg_data = '0;

  // directed rows may carry a hand-written expectation next to the payload
  logic tag_has = 1'b0;
  tlf_pkg::out_t tag_fit = '0;

  // predictor copy of the registers
  logic [tlf_pkg::WIN_W-1:0] inner_win = tlf_pkg::INNER_WINDOW_RST;
  logic [tlf_pkg::WIN_W-1:0] last_win  = tlf_pkg::LAST_WINDOW_RST;
  logic [tlf_pkg::WIN_W-1:0] bound_reg = tlf_pkg::TARGET_BOUND_RST;

  tlf_pkg::out_t pending_fits[$];
  int fail_count = 0;
  int events_sent = 0;
  int fits_seen = 0;
  int accepted_seen = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  typedef struct {
    tlf_pkg::in_t  stim;
    bit            has;
    tlf_pkg::out_t fit;
  } row_t;
  row_t rows[$];

  track_line_fit_with_hit_mask_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---- predictor ---------------------------------------------------------
  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // nearest, halves away from zero; den > 0
  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic tlf_pkg::out_t fit_event(tlf_pkg::in_t e);
    tlf_pkg::out_t r;
    longint p[tlf_pkg::NUM_PLANES];
    longint z[tlf_pkg::NUM_PLANES];
    longint res;
    longint n, sz, sp, szz, szp, den, slp, icp, s1;
    longint unsigned chi, sq, lhs, rhs, mag;
    logic [tlf_pkg::NUM_PLANES-1:0] m;
    longint a, win;
    r = '0;
    m = '0;
    p = '{longint'(e.pos_0), longint'(e.pos_1), longint'(e.pos_2),
          longint'(e.pos_3), longint'(e.pos_4)};
    z = '{longint'(e.z_0), longint'(e.z_1), longint'(e.z_2),
          longint'(e.z_3), longint'(e.z_4)};
    for (int i = 0; i < tlf_pkg::NUM_PLANES; i++) begin
      win = (i == tlf_pkg::NUM_PLANES - 1) ? longint'(last_win) : longint'(inner_win);
      a = (p[i] < 0) ? -p[i] : p[i];
      if (e.timing_ok[i] && a < win) m[i] = 1'b1;
    end
    r.hit_mask = m;
    if (!tlf_pkg::mask_fittable(m)) return r;
    n = 0; sz = 0; sp = 0; szz = 0; szp = 0;
    for (int i = 0; i < tlf_pkg::NUM_PLANES; i++) begin
      if (m[i]) begin
        n++;
        sz += z[i];
        sp += p[i];
        szz += z[i] * z[i];
        szp += z[i] * p[i];
      end
    end
    den = n * szz - sz * sz;
    if (den <= 0) return r;  // all hit planes at one z
    slp = sat_s32(div_nearest((n * szp - sz * sp) * Q1, den));
    icp = sat_s32(div_nearest(szz * sp - sz * szp, den));
    lhs = longint'((icp < 0) ? -icp : icp) * Q1;
    s1 = slp + Q1;
    rhs = longint'(bound_reg) * ((s1 < 0) ? -s1 : s1);
    if (!(lhs < rhs)) return r;  // outside target bound, slope -1 included
    chi = 0;
    for (int i = 0; i < tlf_pkg::NUM_PLANES; i++) begin
      res = sat_s32(div_nearest(p[i] * Q1 - slp * z[i] - icp * Q1, Q1));
      case (i)
        0: r.residual_0 = res[31:0];
        1: r.residual_1 = res[31:0];
        2: r.residual_2 = res[31:0];
        3: r.residual_3 = res[31:0];
        default: r.residual_4 = res[31:0];
      endcase
      if (m[i]) begin
        mag = (res < 0) ? -res : res;
        sq = mag * mag;
        chi = (sq > tlf_pkg::CHI_MAX || chi + sq > tlf_pkg::CHI_MAX)
            ? tlf_pkg::CHI_MAX : chi + sq;
      end
    end
    r.accepted = 1'b1;
    r.slope = slp[31:0];
    r.intercept = icp[31:0];
    r.chi_square = chi[47:0];
    r.degrees_free = 2'(n - 2);
    return r;
  endfunction

  // ---- checking ----------------------------------------------------------
  task automatic cmp(string nm, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", nm, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    tlf_pkg::out_t w;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tlf_pkg::CFG_INNER_WINDOW: inner_win <= cfg_data;
          tlf_pkg::CFG_LAST_WINDOW:  last_win  <= cfg_data;
          tlf_pkg::CFG_TARGET_BOUND: bound_reg <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_fits.push_back(tag_has ? tag_fit : fit_event(in_item));
      if (out_valid && !out_stall) begin
        if (pending_fits.size() == 0) begin
          $error("result transaction with no event waiting");
          fail_count++;
        end else begin
          w = pending_fits.pop_front();
          fits_seen++;
          if (out_item.accepted) accepted_seen++;
          cmp("accepted", 64'(w.accepted), 64'(out_item.accepted));
          cmp("hit_mask", 64'(w.hit_mask), 64'(out_item.hit_mask));
          cmp("slope", 64'(w.slope), 64'(out_item.slope));
          cmp("intercept", 64'(w.intercept), 64'(out_item.intercept));
          cmp("chi_square", 64'(w.chi_square), 64'(out_item.chi_square));
          cmp("degrees_free", 64'(w.degrees_free), 64'(out_item.degrees_free));
          cmp("residual_0", 64'(w.residual_0), 64'(out_item.residual_0));
          cmp("residual_1", 64'(w.residual_1), 64'(out_item.residual_1));
          cmp("residual_2", 64'(w.residual_2), 64'(out_item.residual_2));
          cmp("residual_3", 64'(w.residual_3), 64'(out_item.residual_3));
          cmp("residual_4", 64'(w.residual_4), 64'(out_item.residual_4));
        end
      end
    end
  end

  // ---- receiver: random stall bursts, one long hold-off on request -------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---- watchdog ----------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---- stimulus helpers --------------------------------------------------
  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic tlf_pkg::in_t build_event(
      longint p0, longint p1, longint p2, longint p3, longint p4,
      longint z0, longint z1, longint z2, longint z3, longint z4,
      logic [tlf_pkg::NUM_PLANES-1:0] t);
    tlf_pkg::in_t e;
    e.pos_0 = clip16(p0); e.pos_1 = clip16(p1); e.pos_2 = clip16(p2);
    e.pos_3 = clip16(p3); e.pos_4 = clip16(p4);
    e.z_0 = clip16(z0); e.z_1 = clip16(z1); e.z_2 = clip16(z2);
    e.z_3 = clip16(z3); e.z_4 = clip16(z4);
    e.timing_ok = t;
    return e;
  endfunction

  // mostly tracks near a straight line, the rest raw noise
  function automatic tlf_pkg::in_t random_event();
    longint zb, stp, slp, icp, nz;
    longint zz[tlf_pkg::NUM_PLANES];
    longint pp[tlf_pkg::NUM_PLANES];
    logic [tlf_pkg::NUM_PLANES-1:0] t;
    tlf_pkg::in_t e;
    if ($urandom_range(0, 9) < 7) begin
      zb = longint'($urandom_range(0, 20000)) - 10000;
      stp = ($urandom_range(0, 19) == 0) ? 0 : longint'($urandom_range(1, 3000));
      slp = longint'($urandom_range(0, 4 * 65536)) - 2 * 65536;
      icp = longint'($urandom_range(0, 4000)) - 2000;
      nz = ($urandom_range(0, 9) == 0) ? 3000 : 30;
      for (int i = 0; i < tlf_pkg::NUM_PLANES; i++) begin
        zz[i] = zb + i * stp + longint'($urandom_range(0, 40)) - 20;
        pp[i] = icp + (slp * zz[i]) / Q1 + longint'($urandom_range(0, 2 * nz)) - nz;
      end
      t = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'h1f;
      e = build_event(pp[0], pp[1], pp[2], pp[3], pp[4],
                      zz[0], zz[1], zz[2], zz[3], zz[4], t);
    end else begin
      e = tlf_pkg::in_t'(($bits(tlf_pkg::in_t))'({$urandom, $urandom, $urandom,
                                                  $urandom, $urandom, $urandom}));
    end
    return e;
  endfunction

  task automatic send_event(tlf_pkg::in_t e, bit has, tlf_pkg::out_t f);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_item <= e;
    tag_has <= has;
    tag_fit <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    events_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [tlf_pkg::CFG_IDX_W-1:0] idx,
                           logic [tlf_pkg::WIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every pending result, then let the pipeline run dry
  task automatic drain();
    in_valid <= 1'b0;
    tag_has <= 1'b0;
    while (pending_fits.size() != 0) @(negedge clk);
    repeat (FLUSH_CYCLES) @(negedge clk);
  endtask

  // ---- main sequence -----------------------------------------------------
  initial begin
    row_t rw;
    tlf_pkg::out_t f;
    logic [tlf_pkg::WIN_W-1:0] iw, lw, tb;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows, reset register values
    // no timing: empty mask, nothing fitted
    rw.stim = build_event(0, 0, 0, 0, 0, 0, 16, 32, 48, 64, 5'h00);
    rw.has = 1'b1; rw.fit = '0; rows.push_back(rw);
    // most negative position never counts as a hit
    rw.stim = build_event(-32768, -32768, -32768, -32768, -32768,
                          0, 16, 32, 48, 64, 5'h1f);
    rw.has = 1'b1; rw.fit = '0; rows.push_back(rw);
    // every plane hit at one z: singular
    rw.stim = build_event(0, 10, -10, 5, 3, 100, 100, 100, 100, 100, 5'h1f);
    f = '0; f.hit_mask = 5'h1f;
    rw.has = 1'b1; rw.fit = f; rows.push_back(rw);
    // exact slope one through the origin
    rw.stim = build_event(0, 16, 32, 48, 64, 0, 16, 32, 48, 64, 5'h1f);
    f = '0; f.hit_mask = 5'h1f; f.accepted = 1'b1; f.slope = 32'sd65536;
    f.degrees_free = 2'd3;
    rw.has = 1'b1; rw.fit = f; rows.push_back(rw);
    // slope of minus one never passes the bound
    rw.stim = build_event(0, -16, -32, -48, -64, 0, 16, 32, 48, 64, 5'h1f);
    f = '0; f.hit_mask = 5'h1f;
    rw.has = 1'b1; rw.fit = f; rows.push_back(rw);
    // masks that are never fitted, and fittable neighbours
    for (int t = 3; t <= 17; t++) begin
      rw.stim = build_event(5, 21, 38, 50, 66, 0, 16, 32, 48, 64, 5'(t));
      rw.has = 1'b0; rows.push_back(rw);
    end
    // field extremes, checked by the predictor
    rw.has = 1'b0;
    rw.stim = build_event(32767, 32767, 32767, 32767, 32767,
                          -32768, -100, 0, 100, 32767, 5'h1f);
    rows.push_back(rw);
    rw.stim = build_event(2399, -2399, 1599, -1599, 1599,
                          -32768, -16000, 0, 16000, 32767, 5'h1f);
    rows.push_back(rw);
    rw.stim = build_event(2400, 100, -100, 0, 1600, -30000, -10, 10, 30000, 500, 5'h1f);
    rows.push_back(rw);

    foreach (rows[i]) send_event(rows[i].stim, rows[i].has, rows[i].fit);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin iw = 15'd32767; lw = 15'd32767; tb = 15'd32767; end
        1: begin iw = 15'd0; lw = 15'd0; tb = 15'd0; end
        2: begin
          iw = 15'($urandom_range(500, 32767));
          lw = 15'($urandom_range(500, 32767));
          tb = 15'($urandom_range(0, 32767));
        end
        3: begin iw = 15'd32767; lw = 15'd1; tb = 15'd1; end
        default: begin
          iw = tlf_pkg::INNER_WINDOW_RST;
          lw = tlf_pkg::LAST_WINDOW_RST;
          tb = tlf_pkg::TARGET_BOUND_RST;
        end
      endcase
      write_reg(tlf_pkg::CFG_INNER_WINDOW, iw);
      write_reg(tlf_pkg::CFG_LAST_WINDOW, lw);
      write_reg(tlf_pkg::CFG_TARGET_BOUND, tb);
      if (ph == NUM_PHASES - 1) write_reg(CFG_UNUSED, 15'd7);
      // fill the pipeline against a held output once
      if (ph == 0) hold_req = 1'b1;
      for (int k = 0; k < PHASE_EVENTS; k++) begin
        if (ph == NUM_PHASES - 1 && k >= PHASE_EVENTS - QUIET_EVENTS) quiet = 1'b1;
        send_event(random_event(), 1'b0, '0);
      end
    end

    drain();
    $display("covered %0d events over %0d register settings", events_sent, NUM_PHASES + 1);
    $display("%0d results checked, %0d accepted fits", fits_seen, accepted_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/tlf_pkg.sv
rtl/tlf_hit_lane.sv
rtl/tlf_merge.sv
rtl/tlf_div.sv
rtl/tlf_res_lane.sv
rtl/track_line_fit_with_hit_mask_core.sv
tb/sv/testbench.sv
